// File: rtl/cartridge_bank_controller_unit_assert.svh
// Assertion macros for the cartridge bank controller.
// Included by the top level; depends on nothing else.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define CBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartridge bank controller check failed");
`define CBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartridge bank controller check failed");
`else
`define CBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/cbc_pkg.sv
// Shared types and constants of the cartridge bank controller.
// No dependencies; imported by every module of the block.
package cbc_pkg;

    typedef enum logic [1:0] {
        KIND_ROM_READ  = 2'd0,
        KIND_CTRL_WR   = 2'd1,
        KIND_RAM_READ  = 2'd2,
        KIND_RAM_WRITE = 2'd3
    } t_kind;

    localparam logic [2:0] MAP_ROM_ONLY = 3'd0;
    localparam logic [2:0] MAP_MBC1     = 3'd1;
    localparam logic [2:0] MAP_MBC2     = 3'd2;
    localparam logic [2:0] MAP_MBC3     = 3'd3;

    localparam logic [1:0] CFG_MAPPER   = 2'd0;
    localparam logic [1:0] CFG_RAM_SIZE = 2'd1;
    localparam logic [1:0] CFG_PRESENT  = 2'd2;

    localparam logic [2:0] SIZE_SMALL  = 3'd1;
    localparam logic [2:0] SIZE_FULL_A = 3'd2;
    localparam logic [2:0] SIZE_FULL_B = 3'd3;
    localparam logic [2:0] SIZE_FULL_C = 3'd4;

    localparam logic [3:0]  ENABLE_CODE     = 4'hA;
    localparam logic [12:0] SMALL_RAM_BYTES = 13'h800;
    localparam logic [12:0] NIBBLE_CELLS    = 13'h200;
    localparam int          ROM_OFFSET_W    = 14;   // 16 KB ROM banks
    localparam int          ROM_BANK_W      = 7;
    localparam int          ROM_ADDR_W      = ROM_OFFSET_W + ROM_BANK_W;

    typedef struct packed {
        logic [5:0] rom_bank_low;
        logic [1:0] rom_bank_high;
        logic [1:0] ram_bank_select;
        logic       banking_mode;
        logic       ram_enable;
    } t_bank_state;

endpackage

// File: rtl/cbc_bank.sv
// Bank registers and control write decode of the cartridge bank controller.
// Depends on cbc_pkg.
module cbc_bank import cbc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,     // mapped control write transfer
    input  logic [2:0]  i_mapper,
    input  logic [14:0] i_addr,
    input  logic [7:0]  i_data,
    output t_bank_state o_state,     // state before the current write
    output t_bank_state o_next       // state after the current write
);

    t_bank_state r_state;
    t_bank_state n_state;
    logic        enable_val;
    logic [5:0]  low5;
    logic [5:0]  low4;
    logic [5:0]  low6;

    always_comb begin
        enable_val = (i_data[3:0] == ENABLE_CODE);
        low5 = (i_data[4:0] == 5'd0) ? 6'd1 : {1'b0, i_data[4:0]};
        low4 = (i_data[3:0] == 4'd0) ? 6'd1 : {2'b00, i_data[3:0]};
        low6 = (i_data[5:0] == 6'd0) ? 6'd1 : i_data[5:0];
        n_state = r_state;
        if (i_wr_en) begin
            unique case (i_mapper)
                MAP_MBC1: begin
                    unique case (i_addr[14:13])
                        2'd3: n_state.banking_mode = i_data[0];
                        2'd2: begin
                            if (r_state.banking_mode) begin
                                n_state.ram_bank_select = i_data[1:0];
                            end else begin
                                n_state.rom_bank_high = i_data[1:0];
                            end
                        end
                        2'd1: n_state.rom_bank_low = low5;
                        default: n_state.ram_enable = enable_val;
                    endcase
                end
                MAP_MBC2: begin
                    // Address bit 8 picks the bank register over the enable latch.
                    if (!i_addr[14]) begin
                        if (i_addr[8]) begin
                            n_state.rom_bank_low = low4;
                        end else begin
                            n_state.ram_enable = enable_val;
                        end
                    end
                end
                MAP_MBC3: begin
                    unique case (i_addr[14:13])
                        2'd3: ;
                        2'd2: begin
                            if (i_data[3:2] == 2'd0) begin
                                n_state.ram_bank_select = i_data[1:0];
                            end
                        end
                        2'd1: n_state.rom_bank_low = low6;
                        default: n_state.ram_enable = enable_val;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.rom_bank_low    <= 6'd1;
            r_state.rom_bank_high   <= 2'd0;
            r_state.ram_bank_select <= 2'd0;
            r_state.banking_mode    <= 1'b0;
            r_state.ram_enable      <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

endmodule

// File: rtl/cartridge_bank_controller_unit.sv
// Top level of the cartridge bank controller: bus access stream in, result stream out.
// Depends on cbc_pkg, cbc_bank and cartridge_bank_controller_unit_assert.svh.
//
// Usage: each transfer on the s_axis side is one bus access (ROM read, control write,
// RAM read or RAM write); each access gives exactly one result transfer on m_axis,
// in order. Configuration (mapper kind, RAM size code, cartridge present) is written
// through i_cfg_we / i_cfg_index / i_cfg_data while no access is in flight.
// An input transfer passes through the middle stage, which waits for the cartridge
// RAM read (synchronous RAM), and then the output register before its result is valid.
// One access is taken every cycle while the output is not stalled; the bank registers
// update in the cycle of the transfer, so a following access sees them at once, and the
// RAM is written in the same cycle, so a following read of that entry sees the new byte.
// If the receiver stalls, the result waits in the output register and one more access
// waits in the middle stage; the input then deasserts tready until the output drains.
// Reset clears the configuration, the bank registers (ROM bank 1, everything else 0)
// and the stream valids. The RAM holds undefined data until written.
`include "cartridge_bank_controller_unit_assert.svh"

module cartridge_bank_controller_unit import cbc_pkg::*; #(
    parameter int RAM_BANK_BYTES = 8192,
    parameter int RAM_BANKS      = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_data[7:0], rom_address[28:8],
                                        // ram_enabled[29], invalid_write[30], zero[31]
    output logic        m_axis_tuser    // rom_valid
);

    localparam int RAM_TOTAL = RAM_BANK_BYTES * RAM_BANKS;
    localparam int AW        = $clog2(RAM_TOTAL);

    // Configuration registers.
    logic [2:0] r_mapper;
    logic [2:0] r_ram_size;
    logic       r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper   <= 3'd0;
            r_ram_size <= 3'd0;
            r_present  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAPPER:   r_mapper   <= i_cfg_data;
                CFG_RAM_SIZE: r_ram_size <= i_cfg_data;
                CFG_PRESENT:  r_present  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input decode.
    t_kind       in_kind;
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic        accept;
    logic        out_free;

    assign in_kind = t_kind'(s_axis_tuser);
    assign in_addr = s_axis_tdata[15:0];
    assign in_data = s_axis_tdata[23:16];

    // Pipeline control.
    logic r_s1_valid;
    logic r_out_valid;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Bank registers.
    t_bank_state bank;
    t_bank_state bank_next;
    logic        ctrl_wr;
    logic        in_rom_window;

    assign in_rom_window = r_present && !in_addr[15];
    assign ctrl_wr       = accept && (in_kind == KIND_CTRL_WR) && in_rom_window;

    cbc_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (ctrl_wr),
        .i_mapper(r_mapper),
        .i_addr  (in_addr[14:0]),
        .i_data  (in_data),
        .o_state (bank),
        .o_next  (bank_next)
    );

    // ROM address mapping.
    logic [ROM_BANK_W-1:0] win_bank;
    logic                  rom_hit;
    logic [ROM_ADDR_W-1:0] rom_addr;

    always_comb begin
        unique case (r_mapper)
            MAP_MBC1: begin
                if (bank.banking_mode) begin
                    win_bank = {1'b0, bank.rom_bank_low};
                end else begin
                    win_bank = {bank.rom_bank_high, 5'd0} | {1'b0, bank.rom_bank_low};
                end
            end
            MAP_MBC2, MAP_MBC3: win_bank = {1'b0, bank.rom_bank_low};
            default: win_bank = ROM_BANK_W'(1);
        endcase
        rom_hit = (in_kind == KIND_ROM_READ) && in_rom_window;
        if (!rom_hit) begin
            rom_addr = '0;
        end else if (in_addr[14]) begin
            rom_addr = {win_bank, in_addr[ROM_OFFSET_W-1:0]};
        end else begin
            rom_addr = {{ROM_BANK_W{1'b0}}, in_addr[ROM_OFFSET_W-1:0]};
        end
    end

    // RAM window mapping.
    logic [12:0]   ram_off;
    logic          in_ram_window;
    logic [1:0]    act_bank;
    logic [1:0]    bank_mod;
    logic          ram_hit;
    logic          ram_nibble;
    logic [16:0]   idx_full;
    logic [AW-1:0] ram_idx;
    logic          off_in_bank;

    always_comb begin
        ram_off       = in_addr[12:0];
        in_ram_window = r_present && (in_addr[15:13] == 3'b101);
        off_in_bank   = ({1'b0, ram_off} < 14'(RAM_BANK_BYTES));
        if ((r_mapper == MAP_MBC1 && bank.banking_mode) || r_mapper == MAP_MBC3) begin
            act_bank = bank.ram_bank_select;
        end else begin
            act_bank = 2'd0;
        end
        // Bank number modulo the bank count; the value is narrow.
        bank_mod = act_bank;
        for (int i = 0; i < 3; i++) begin
            if (32'(bank_mod) >= RAM_BANKS) begin
                bank_mod = bank_mod - 2'(RAM_BANKS);
            end
        end
        ram_hit    = 1'b0;
        ram_nibble = 1'b0;
        idx_full   = 17'(ram_off);
        case (r_ram_size)
            SIZE_SMALL: begin
                ram_hit = (ram_off < SMALL_RAM_BYTES) && off_in_bank;
            end
            SIZE_FULL_A, SIZE_FULL_B, SIZE_FULL_C: begin
                ram_hit  = off_in_bank;
                idx_full = 17'(bank_mod) * 17'(RAM_BANK_BYTES) + 17'(ram_off);
            end
            default: begin
                ram_hit    = (r_mapper == MAP_MBC2) && (ram_off < NIBBLE_CELLS);
                ram_nibble = 1'b1;
            end
        endcase
        ram_hit = ram_hit && in_ram_window;
        ram_idx = idx_full[AW-1:0];
    end

    // Cartridge RAM, one access per transfer.
    logic [7:0] r_mem [RAM_TOTAL];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (accept && ram_hit) begin
            if (in_kind == KIND_RAM_WRITE) begin
                r_mem[ram_idx] <= ram_nibble ? {4'd0, in_data[3:0]} : in_data;
            end else if (in_kind == KIND_RAM_READ) begin
                r_rdata <= r_mem[ram_idx];
            end
        end
    end

    // Middle stage: waits for the RAM read data.
    logic                  r_s1_ram_rd;
    logic                  r_s1_ram_hit;
    logic                  r_s1_nibble;
    logic [ROM_ADDR_W-1:0] r_s1_rom_addr;
    logic                  r_s1_rom_valid;
    logic                  r_s1_ram_en;
    logic                  r_s1_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ram_rd    <= (in_kind == KIND_RAM_READ);
            r_s1_ram_hit   <= ram_hit;
            r_s1_nibble    <= ram_nibble;
            r_s1_rom_addr  <= rom_addr;
            r_s1_rom_valid <= rom_hit;
            r_s1_ram_en    <= bank_next.ram_enable;
            r_s1_invalid   <= ctrl_wr && (r_mapper == MAP_ROM_ONLY);
        end
    end

    // Output register.
    logic [7:0] s1_read_data;
    logic       s1_move;

    always_comb begin
        if (!r_s1_ram_rd) begin
            s1_read_data = 8'h00;
        end else if (!r_s1_ram_hit) begin
            s1_read_data = 8'hFF;
        end else if (r_s1_nibble) begin
            s1_read_data = {4'd0, r_rdata[3:0]};
        end else begin
            s1_read_data = r_rdata;
        end
    end

    assign s1_move = r_s1_valid && out_free;

    logic [31:0] r_out_data;
    logic        r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= {1'b0, r_s1_invalid, r_s1_ram_en, r_s1_rom_addr, s1_read_data};
            r_out_user <= r_s1_rom_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // The RAM read data must not be overwritten while its item waits.
    `CBC_ASSERT_SAME(a_hold_interlock, i_clk, i_rst_n, r_s1_valid && !out_free, !s_axis_tready)
    `CBC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, accept, r_s1_valid)
    `CBC_ASSERT_SAME(a_bank_nonzero, i_clk, i_rst_n, 1'b1, bank.rom_bank_low != 6'd0)
    `CBC_ASSERT_SAME(a_rom_result_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
                     m_axis_tdata[7:0] == 8'h00 && !m_axis_tdata[30])

endmodule
